[rtl/hia_pkg.sv]
// shared types and constants for the handle id allocator
// used by hia_ctrl, hia_dpath, handle_id_allocator and hia_checker
`default_nettype none

package hia_pkg;

	localparam int MAX_IDS = 2048;
	localparam int HW      = 12;                    // handle field width
	localparam int ID_AW   = $clog2(MAX_IDS);       // memory address width
	localparam int CW      = $clog2(MAX_IDS + 1);   // live count / stack depth width

	localparam logic [HW-1:0] MAX_HANDLE = HW'(MAX_IDS);

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_CHECK   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef struct packed {
		logic clr_en;   // clearing pass: zero one live map entry
		logic capture;  // take a request, launch memory reads
		logic exec;     // read data ready, update state and result
	} hia_cmd_t;

	typedef struct packed {
		logic clr_last;     // clearing pass on its last entry
		logic out_blocked;  // result register full and held
	} hia_stat_t;

endpackage

`default_nettype wire

[rtl/handle_id_allocator.sv]
// channel    | valid / stall         | fields
// request    | req_valid / req_stall | action[1:0], handle[11:0]
// response   | rsp_valid / rsp_stall | granted_handle[11:0], hit
//
// each request is handled as a registered read of the live map and free stack,
// followed by the update writes and the result register load.
// after reset a clearing pass zeroes the live map, one entry a cycle, with req_stall
// high throughout.
// a new request is taken while the previous result waits, as long as it is not
// held by rsp_stall; a held result stalls the request side.
// top level: instantiates hia_ctrl and hia_dpath, uses hia_pkg
`default_nettype none

module handle_id_allocator
	import hia_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire logic [1:0]    action,
	input  wire logic [HW-1:0] handle,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic [HW-1:0]      granted_handle,
	output logic               hit
);

	hia_cmd_t  cmd;
	hia_stat_t stat;

	hia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	hia_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.handle         (handle),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.granted_handle (granted_handle),
		.hit            (hit)
	);

endmodule

`default_nettype wire

[rtl/hia_ctrl.sv]
// controller state machine: clearing pass, request capture, execute
// depends on hia_pkg
`default_nettype none

module hia_ctrl
	import hia_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire hia_stat_t stat,
	output hia_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd.clr_en  = (state_q == ST_CLEAR);
		cmd.capture = (state_q == ST_IDLE) && req_valid && !stat.out_blocked;
		cmd.exec    = (state_q == ST_EXEC);
		req_stall   = (state_q != ST_IDLE) || stat.out_blocked;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.capture)
					state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nxt;
	end

endmodule

`default_nettype wire

[rtl/hia_dpath.sv]
// datapath: live map and free stack memories, counters, result register
// depends on hia_pkg
`default_nettype none

module hia_dpath
	import hia_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hia_cmd_t      cmd,
	output hia_stat_t          stat,
	input  wire logic [1:0]    action,
	input  wire logic [HW-1:0] handle,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic [HW-1:0]      granted_handle,
	output logic               hit
);

	logic              live_mem [MAX_IDS];
	logic [HW-1:0]     stack_mem [MAX_IDS];

	logic [ID_AW-1:0]  clr_cnt_q;
	logic [CW-1:0]     free_depth_q;
	logic [CW-1:0]     live_total_q;
	logic              out_valid_q;

	logic [1:0]        act_q;
	logic [HW-1:0]     hdl_q;
	logic              map_rd_q;
	logic [HW-1:0]     stack_rd_q;
	logic [HW-1:0]     grant_q;
	logic              hit_q;

	logic              map_we;
	logic [ID_AW-1:0]  map_wa;
	logic              map_wd;
	logic              push;
	logic              pop;
	logic              inc_live;
	logic              dec_live;
	logic [HW-1:0]     grant_nxt;
	logic              hit_nxt;
	logic              h_ok;
	logic              full;
	logic [HW-1:0]     alloc_g;
	logic [ID_AW-1:0]  hdl_addr;
	logic [ID_AW-1:0]  alloc_addr;
	logic [CW-1:0]     depth_m1;

	assign stat.clr_last    = cmd.clr_en && (clr_cnt_q == {ID_AW{1'b1}});
	assign stat.out_blocked = out_valid_q && rsp_stall;

	assign h_ok       = (hdl_q != '0) && (hdl_q <= MAX_HANDLE);
	assign full       = (live_total_q == CW'(MAX_IDS));
	assign depth_m1   = free_depth_q - CW'(1);
	// empty stack means every issued handle is live, so the next one is count + 1
	assign alloc_g    = (free_depth_q != '0) ? stack_rd_q : HW'(live_total_q + CW'(1));
	assign hdl_addr   = ID_AW'(hdl_q - HW'(1));
	assign alloc_addr = ID_AW'(alloc_g - HW'(1));

	always_comb begin
		map_we    = 1'b0;
		map_wa    = hdl_addr;
		map_wd    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		inc_live  = 1'b0;
		dec_live  = 1'b0;
		grant_nxt = '0;
		hit_nxt   = 1'b0;
		if (cmd.clr_en) begin
			map_we = 1'b1;
			map_wa = clr_cnt_q;
		end else if (cmd.exec) begin
			case (act_q)
				ACT_ALLOC: begin
					if (!full) begin
						map_we    = 1'b1;
						map_wa    = alloc_addr;
						map_wd    = 1'b1;
						pop       = (free_depth_q != '0);
						inc_live  = 1'b1;
						grant_nxt = alloc_g;
						hit_nxt   = 1'b1;
					end
				end
				ACT_RELEASE: begin
					if (h_ok && map_rd_q) begin
						map_we   = 1'b1;
						push     = 1'b1;
						dec_live = 1'b1;
						hit_nxt  = 1'b1;
					end
				end
				ACT_CHECK: begin
					hit_nxt = h_ok && map_rd_q;
				end
				default: begin
					hit_nxt = 1'b0;
				end
			endcase
		end
	end

	// memories, read data registered
	always_ff @(posedge clk) begin
		if (map_we)
			live_mem[map_wa] <= map_wd;
		if (cmd.capture)
			map_rd_q <= live_mem[ID_AW'(handle - HW'(1))];
	end

	always_ff @(posedge clk) begin
		if (push)
			stack_mem[ID_AW'(free_depth_q)] <= hdl_q;
		if (cmd.capture)
			stack_rd_q <= stack_mem[ID_AW'(depth_m1)];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			hdl_q <= handle;
		end
		if (cmd.exec) begin
			grant_q <= grant_nxt;
			hit_q   <= hit_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			free_depth_q <= '0;
			live_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr_en)
				clr_cnt_q <= clr_cnt_q + ID_AW'(1);
			if (push)
				free_depth_q <= free_depth_q + CW'(1);
			else if (pop)
				free_depth_q <= depth_m1;
			if (inc_live)
				live_total_q <= live_total_q + CW'(1);
			else if (dec_live)
				live_total_q <= live_total_q - CW'(1);
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign granted_handle = grant_q;
	assign hit            = hit_q;

endmodule

`default_nettype wire

[rtl/hia_checker.sv]
// port-level checks for handle_id_allocator, attached by bind
// depends on hia_pkg
`default_nettype none

module hia_checker
	import hia_pkg::*;
(
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic [1:0]    action,
	input wire logic [HW-1:0] handle,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire logic [HW-1:0] granted_handle,
	input wire logic          hit
);

	// a taken request keeps the block busy for its execute cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken on back-to-back cycles");

	// a taken request moves to the execute state, which loads the result register and raises rsp_valid
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> ##2 rsp_valid)
		else $error("response missing after request");

	// a granted handle is in range and flagged as a hit
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && granted_handle != '0) |-> (hit && granted_handle <= MAX_HANDLE))
		else $error("bad granted handle");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(granted_handle) && $stable(hit)))
		else $error("stalled response changed");

endmodule

bind handle_id_allocator hia_checker u_hia_checker (.*);

`default_nettype wire
